// ===== rtl/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal text parser
// Character codes, beat payload types, the job record that passes from the
// parser front to the fraction divider, and the power-of-ten table.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int INT_W      = 31;
  localparam int FRAC_ACC_W = 30;
  localparam int FCNT_W     = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dtf_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               overflow;
  } dtf_out_t;

  typedef struct packed {
    logic                  negative;
    logic [INT_W-1:0]      int_acc;
    logic                  int_sat;
    logic [FRAC_ACC_W-1:0] frac_acc;
    logic [FCNT_W-1:0]     frac_count;
  } dtf_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } dtf_q_status_t;

  // Divisor for a fraction of n kept digits; counts above nine clamp to nine.
  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/dtf_front.sv =====
// ----------------------------------------------------------------------------
// dtf_front: character parser
// Classifies one character per beat, accumulates the integer and fraction
// digits, and pushes a finished job into the queue on the last character.
// ----------------------------------------------------------------------------
module dtf_front
  import dtf_pkg::*;
#(
  parameter int FRAC_DIGITS = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dtf_in_t       in_data,
  output logic          q_push,
  output dtf_job_t      q_job,
  input  dtf_q_status_t q_status
);

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_INT  = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [INT_W-1:0]      int_r, int_nxt;
  logic                  sat_r, sat_nxt;
  logic [FRAC_ACC_W-1:0] frac_r, frac_nxt;
  logic [FCNT_W-1:0]     cnt_r, cnt_nxt;

  logic                  accept;
  logic                  digit;
  logic                  space;
  logic [3:0]            dval;
  logic [INT_W+3:0]      int_mul;
  logic [FRAC_ACC_W+3:0] frac_mul;
  logic                  frac_room;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign digit = (in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE);
  assign space = (in_data.ch == CH_SPACE) || ((in_data.ch >= CH_TAB) && (in_data.ch <= CH_CR));
  assign dval  = digit ? 4'(in_data.ch - CH_ZERO) : 4'd0;

  assign int_mul  = ({4'd0, int_r} << 3) + ({4'd0, int_r} << 1) + (INT_W+4)'(dval);
  assign frac_mul = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1) + (FRAC_ACC_W+4)'(dval);
  assign frac_room = cnt_r < FCNT_W'(FRAC_DIGITS);

  always_comb begin
    logic add_int;
    add_int   = 1'b0;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    sat_nxt   = sat_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      PH_SKIP: begin
        if (space) begin
          phase_nxt = PH_SKIP;
        end else if (in_data.ch == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_INT;
        end else if (in_data.ch == CH_PLUS) begin
          phase_nxt = PH_INT;
        end else if (digit) begin
          add_int   = 1'b1;
          phase_nxt = PH_INT;
        end else if (in_data.ch == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_INT: begin
        if (digit) begin
          add_int = 1'b1;
        end else if (in_data.ch == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (digit) begin
          if (frac_room) begin
            frac_nxt = frac_mul[FRAC_ACC_W-1:0];
            cnt_nxt  = cnt_r + FCNT_W'(1);
          end
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
    if (add_int) begin
      if (|int_mul[INT_W+3:INT_W]) begin
        int_nxt = {INT_W{1'b1}};
        sat_nxt = 1'b1;
      end else begin
        int_nxt = int_mul[INT_W-1:0];
      end
    end
  end

  assign q_push           = accept && in_data.last;
  assign q_job.negative   = neg_nxt;
  assign q_job.int_acc    = int_nxt;
  assign q_job.int_sat    = sat_nxt;
  assign q_job.frac_acc   = frac_nxt;
  assign q_job.frac_count = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      int_r   <= '0;
      sat_r   <= 1'b0;
      frac_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      int_r   <= int_nxt;
      sat_r   <= sat_nxt;
      frac_r  <= frac_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/dtf_queue.sv =====
// ----------------------------------------------------------------------------
// dtf_queue: two-entry job queue
// Decouples the character parser from the fraction divider.
// ----------------------------------------------------------------------------
module dtf_queue
  import dtf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtf_job_t      push_job,
  input  logic          pop,
  output dtf_job_t      head_job,
  output dtf_q_status_t status
);

  dtf_job_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head_job     = mem_r[rd_ptr_r];
  assign status.valid = count_r != 2'd0;
  assign status.full  = count_r == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/dtf_back.sv =====
// ----------------------------------------------------------------------------
// dtf_back: fraction divider and result former
// Divides the fraction digits by their power of ten, one quotient bit per
// cycle, then assembles the signed fixed-point result in the output register.
// ----------------------------------------------------------------------------
module dtf_back
  import dtf_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dtf_q_status_t q_status,
  input  dtf_job_t      q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output dtf_out_t      out_data
);

  localparam int BCNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_HOLD = 3'b100
  } bk_state_t;

  bk_state_t             state_r;
  logic [BCNT_W-1:0]     bit_cnt_r;
  logic [FRAC_ACC_W:0]   rem_r;
  logic [FRAC_ACC_W-1:0] div_r;
  logic [FRAC_BITS-1:0]  quo_r;
  logic                  neg_r;
  logic [INT_W-1:0]      int_r;
  logic                  sat_r;
  logic                  out_valid_r;
  dtf_out_t              out_r;

  logic [FRAC_ACC_W+1:0] rem2;
  logic [FRAC_ACC_W+1:0] diff;
  logic                  ge;
  logic                  out_free;
  logic [31:0]           frac32;
  logic [63:0]           mag;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {2'b00, div_r};
  assign ge   = rem2 >= {2'b00, div_r};

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == BK_IDLE) && q_status.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign frac32 = 32'(quo_r) << (32 - FRAC_BITS);
  assign mag    = {1'b0, int_r, frac32};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r     <= {1'b0, q_job.frac_acc};
      div_r     <= pow10(q_job.frac_count);
      neg_r     <= q_job.negative;
      int_r     <= q_job.int_acc;
      sat_r     <= q_job.int_sat;
      bit_cnt_r <= BCNT_W'(FRAC_BITS - 1);
    end else if (state_r == BK_DIV) begin
      rem_r     <= ge ? diff[FRAC_ACC_W:0] : rem2[FRAC_ACC_W:0];
      quo_r     <= (FRAC_BITS)'({quo_r, ge});
      bit_cnt_r <= bit_cnt_r - BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == BK_HOLD) && out_free) begin
      out_r.value    <= neg_r ? -mag : mag;
      out_r.overflow <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (q_status.valid) begin
            state_r <= BK_DIV;
          end
        end
        BK_DIV: begin
          if (bit_cnt_r == '0) begin
            state_r <= BK_HOLD;
          end
        end
        BK_HOLD: begin
          if (out_free) begin
            state_r <= BK_IDLE;
          end
        end
        default: begin
          state_r <= BK_IDLE;
        end
      endcase
      if ((state_r == BK_HOLD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/decimal_text_to_fixed_point_top.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top: decimal text to signed Q31.32
// Result: once its last character beat is accepted, a string's job passes
//   through the queue, the bit-serial divider and the output register.
// Throughput: one character beat per cycle while the queue has room; the
//   bit-serial fraction divider works on one string at a time, which sets the string rate.
// Reset: synchronous, active low; parser, queue and divider return to idle.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_top
  import dtf_pkg::*;
#(
  parameter int FRAC_DIGITS = 9,
  parameter int FRAC_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dtf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dtf_out_t out_data
);

  // The front parses each accepted character beat as it arrives. When a beat
  // carries the last flag, the finished integer part, sign, saturation flag
  // and fraction digits travel as one job into a two-entry queue.
  logic          q_push;
  logic          q_pop;
  dtf_job_t      push_job;
  dtf_job_t      head_job;
  dtf_q_status_t q_status;

  dtf_front #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_job    (push_job),
    .q_status (q_status)
  );

  // The queue lets the parser keep taking characters of the next string
  // while the divider still works on the previous one.
  dtf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // The back divides the fraction digits by their power of ten with a
  // restoring divider, one quotient bit per cycle, and forms the result in
  // an output register that holds while the result beat is stalled.
  dtf_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A job is only pushed when the queue has room for it.
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("job pushed into a full queue");

  // The divider only takes a job that is present.
  a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_status.valid)
    else $error("job popped from an empty queue");

  // No result beat is offered right after reset.
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered after reset");

endmodule
